// ----- hdl/mpm_pkg.sv -----
package mpm_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int CH_COUNT      = 4;
	localparam int CH_BITS       = 2;
	localparam int WORD_BYTES    = 4;
	localparam int READOUT_BYTES = CH_COUNT * WORD_BYTES;
	localparam int CNT_BITS      = 5;

	localparam logic [7:0] CMD_READOUT = 8'h74;
	localparam logic [7:0] BYTE_END    = 8'h24;
	localparam logic [7:0] BYTE_QUERY  = 8'h3F;
	localparam logic [7:0] BYTE_NONE   = 8'h00;

	localparam logic [1:0] PHASE_START = 2'd1;
	localparam logic [1:0] PHASE_STOP  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	typedef enum logic [1:0] {
		SEL_SINGLE,
		SEL_BYTE,
		SEL_END
	} out_sel_t;

	typedef struct packed {
		logic     accept;
		logic     load;
		out_sel_t sel;
		logic [CNT_BITS-2:0] byte_idx;
	} cmd_t;

	typedef struct packed {
		logic is_readout;
	} status_t;

endpackage

// ----- hdl/mpm_ctrl.sv -----
module mpm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  mpm_pkg::status_t status,
	output mpm_pkg::cmd_t    cmd
);
	import mpm_pkg::*;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                out_free;
	logic                accept;
	logic                at_end;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign at_end   = cnt_q == CNT_BITS'(READOUT_BYTES);

	always_comb begin
		cmd.accept   = accept;
		cmd.load     = 1'b0;
		cmd.sel      = SEL_SINGLE;
		cmd.byte_idx = cnt_q[CNT_BITS-2:0];
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = accept && !status.is_readout;
			end
			ST_DUMP: begin
				cmd.load = out_free;
				cmd.sel  = at_end ? SEL_END : SEL_BYTE;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && status.is_readout) begin
						state_q <= ST_DUMP;
						cnt_q   <= '0;
					end
				end
				ST_DUMP: begin
					// advance one byte per transaction taken, return after the terminator
					if (out_free) begin
						cnt_q <= cnt_q + 1'b1;
						if (at_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/mpm_datapath.sv -----
module mpm_datapath #(
	parameter int TIME_BITS = mpm_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mpm_pkg::cmd_t                cmd,
	output mpm_pkg::status_t             status,
	input  logic                         tick,
	input  logic                         edge_req,
	input  logic                         host_valid,
	input  logic [7:0]                   host_byte,
	output logic                         tx_valid,
	output logic [7:0]                   tx_byte,
	output logic [mpm_pkg::CH_BITS-1:0]  channel_select,
	output logic                         last
);
	import mpm_pkg::*;

	localparam int STORE_BITS = TIME_BITS - 1;
	localparam int PAD_BITS   = 8 * WORD_BYTES - STORE_BITS;

	logic [TIME_BITS-1:0]  time_q;
	logic [TIME_BITS-1:0]  start_q;
	logic [TIME_BITS-1:0]  elapsed;
	logic [1:0]            phase_q;
	logic [CH_BITS-1:0]    chan_q;
	logic [CH_BITS-1:0]    chan_nx;
	logic [STORE_BITS-1:0] store_q [CH_COUNT];
	logic                  stop_edge;
	logic [8*WORD_BYTES-1:0] word;

	logic                  tx_valid_q;
	logic [7:0]            tx_byte_q;
	logic [CH_BITS-1:0]    chan_out_q;
	logic                  last_q;

	assign status.is_readout = host_valid && (host_byte == CMD_READOUT);

	assign stop_edge = cmd.accept && edge_req && (phase_q == PHASE_STOP);
	assign chan_nx   = stop_edge ? chan_q + 1'b1 : chan_q;
	assign elapsed   = time_q - start_q;

	assign word = {{PAD_BITS{1'b0}}, store_q[cmd.byte_idx[3:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			start_q <= '0;
			phase_q <= '0;
			chan_q  <= '0;
			for (int i = 0; i < CH_COUNT; i++) begin
				store_q[i] <= '0;
			end
		end else if (cmd.accept) begin
			// edge sees the time before this transaction's tick
			if (edge_req) begin
				if (phase_q == PHASE_START) begin
					start_q <= time_q;
				end
				if (phase_q == PHASE_STOP) begin
					store_q[chan_q] <= elapsed[TIME_BITS-1:1];
				end
				phase_q <= phase_q + 1'b1;
			end
			chan_q <= chan_nx;
			if (tick) begin
				time_q <= time_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			unique case (cmd.sel)
				SEL_SINGLE: begin
					tx_valid_q <= host_valid;
					tx_byte_q  <= host_valid ? BYTE_QUERY : BYTE_NONE;
					chan_out_q <= chan_nx;
					last_q     <= 1'b1;
				end
				SEL_BYTE: begin
					tx_valid_q <= 1'b1;
					tx_byte_q  <= word[8*cmd.byte_idx[1:0] +: 8];
					chan_out_q <= chan_q;
					last_q     <= 1'b0;
				end
				SEL_END: begin
					tx_valid_q <= 1'b1;
					tx_byte_q  <= BYTE_END;
					chan_out_q <= chan_q;
					last_q     <= 1'b1;
				end
				default: begin
					tx_valid_q <= 1'b0;
					tx_byte_q  <= BYTE_NONE;
					chan_out_q <= chan_q;
					last_q     <= 1'b1;
				end
			endcase
		end
	end

	assign tx_valid       = tx_valid_q;
	assign tx_byte        = tx_byte_q;
	assign channel_select = chan_out_q;
	assign last           = last_q;

endmodule

// ----- hdl/multichannel_period_meter_top.sv -----
// Multichannel period meter.
// Input channel (in_valid/in_stall): one transaction per timer clock, carrying
// tick, edge_req and an optional host command byte. Every four sensor edges a
// half period is stored for the selected channel and channel_select advances.
// Output channel (out_valid/out_stall): one reply transaction per input, or
// seventeen for the readout command 't' (16 value bytes, low byte first, then
// '$'); last marks the final one. A host byte other than 't' answers '?'.
// The reply is registered in the cycle after its input transaction.
// Throughput: one input per cycle while the output is taken; a readout holds
// in_stall after its transaction until the dump has sent the value bytes and
// the terminator; the dump steps one byte per transaction taken, so a
// receiver stall prolongs it.
// A receiver stall holds the reply register and stalls the input side.
// Reset clears the time count, start time, edge phase, channel and the four
// stored values; no output is pending after reset.
module multichannel_period_meter_top #(
	parameter int TIME_BITS = mpm_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         tick,
	input  logic                         edge_req,
	input  logic                         host_valid,
	input  logic [7:0]                   host_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         tx_valid,
	output logic [7:0]                   tx_byte,
	output logic [mpm_pkg::CH_BITS-1:0]  channel_select,
	output logic                         last
);
	import mpm_pkg::*;

	cmd_t    cmd;
	status_t status;

	mpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mpm_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.tick           (tick),
		.edge_req       (edge_req),
		.host_valid     (host_valid),
		.host_byte      (host_byte),
		.tx_valid       (tx_valid),
		.tx_byte        (tx_byte),
		.channel_select (channel_select),
		.last           (last)
	);

endmodule

// ----- hdl/mpm_checker.sv -----
module mpm_props (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       host_valid,
	input logic [7:0] host_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       last
);
	import mpm_pkg::*;

	// a stalled reply holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last))
		else $error("stalled reply changed");

	// a readout command blocks the input side while the dump runs
	a_readout_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && host_valid && host_byte == CMD_READOUT |=> in_stall)
		else $error("input accepted during readout");

	// only readout bytes are not the final reply
	a_notlast_sent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> tx_valid)
		else $error("intermediate reply without tx_valid");

	// an empty reply is a single zero byte
	a_empty_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> last && tx_byte == BYTE_NONE)
		else $error("malformed empty reply");

endmodule

bind multichannel_period_meter_top mpm_props u_mpm_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.host_valid (host_valid),
	.host_byte  (host_byte),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.tx_valid   (tx_valid),
	.tx_byte    (tx_byte),
	.last       (last)
);
